FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HSL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define HSL_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define HSL_ASSERT(label, clk, rst, prop)
`define HSL_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL converter package
// Word types, pipeline cell types and constants of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int QUOT_BITS = 12;

   localparam logic [14:0] HUE_SECTOR = 15'd3840;
   localparam logic [14:0] HUE_FULL   = 15'd23040;
   localparam logic [14:0] BASE_RED   = 15'd0;
   localparam logic [14:0] BASE_GREEN = 15'd7680;
   localparam logic [14:0] BASE_BLUE  = 15'd15360;
   localparam logic [9:0]  SUM_FULL   = 10'd510;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  lightness;
   } hsl_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] sector;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       dneg;
      logic [7:0] dmag;
   } prep_type;

   typedef struct packed {
      logic [7:0]           divisor;
      logic [7:0]           rem;
      logic [QUOT_BITS-1:0] work;
   } hue_lane_type;

   typedef struct packed {
      logic [8:0]           divisor;
      logic [8:0]           rem;
      logic [QUOT_BITS-1:0] work;
   } sat_lane_type;

   typedef struct packed {
      logic         valid;
      logic         grey;
      logic         dneg;
      logic [1:0]   sector;
      logic [7:0]   lightness;
      hue_lane_type hue;
      sat_lane_type sat;
   } cell_type;

endpackage

FILE: rtl/hsl_prep.sv
// ----------------------------------------------------------------------------
// HSL front stage
// Finds max, min and hue sector, then forms both dividends for the cell row.
// ----------------------------------------------------------------------------
module hsl_prep
   import hsl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      req_valid,
   input  pixel_type req_word,
   output cell_type  head
);

   prep_type   prep_ff;
   prep_type   prep_in;
   logic [8:0] diff;
   logic [7:0] chroma;
   logic [8:0] sum;
   logic [9:0] sum_rnd;
   logic [8:0] sum_rest;
   logic [7:0] den;
   logic [19:0] hue_num;
   logic [16:0] sat_num;

   always_comb begin
      prep_in.valid = req_valid;
      prep_in.hi = req_word.red;
      if (req_word.green > prep_in.hi) begin
         prep_in.hi = req_word.green;
      end
      if (req_word.blue > prep_in.hi) begin
         prep_in.hi = req_word.blue;
      end
      prep_in.lo = req_word.red;
      if (req_word.green < prep_in.lo) begin
         prep_in.lo = req_word.green;
      end
      if (req_word.blue < prep_in.lo) begin
         prep_in.lo = req_word.blue;
      end
      if (req_word.red >= req_word.green && req_word.red >= req_word.blue) begin
         prep_in.sector = SECTOR_RED;
         diff = {1'b0, req_word.green} - {1'b0, req_word.blue};
      end else if (req_word.green >= req_word.blue) begin
         prep_in.sector = SECTOR_GREEN;
         diff = {1'b0, req_word.blue} - {1'b0, req_word.red};
      end else begin
         prep_in.sector = SECTOR_BLUE;
         diff = {1'b0, req_word.red} - {1'b0, req_word.green};
      end
      prep_in.dneg = diff[8];
      prep_in.dmag = diff[8] ? 8'(-diff) : diff[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (en) begin
         prep_ff.valid <= prep_in.valid;
      end
      if (en) begin
         prep_ff.sector <= prep_in.sector;
         prep_ff.hi     <= prep_in.hi;
         prep_ff.lo     <= prep_in.lo;
         prep_ff.dneg   <= prep_in.dneg;
         prep_ff.dmag   <= prep_in.dmag;
      end
   end

   always_comb begin
      chroma   = prep_ff.hi - prep_ff.lo;
      sum      = {1'b0, prep_ff.hi} + {1'b0, prep_ff.lo};
      sum_rnd  = {1'b0, sum} + 10'd1;
      sum_rest = 9'(SUM_FULL - {1'b0, sum});
      den      = (sum <= sum_rest) ? sum[7:0] : sum_rest[7:0];
      hue_num  = ({12'd0, prep_ff.dmag} << 12) - ({12'd0, prep_ff.dmag} << 8);
      sat_num  = ({9'd0, chroma} << 9) - ({9'd0, chroma} << 1) + {9'd0, den};

      head.valid       = prep_ff.valid;
      head.grey        = (chroma == 8'd0);
      head.dneg        = prep_ff.dneg;
      head.sector      = prep_ff.sector;
      head.lightness   = sum_rnd[8:1];
      head.hue.divisor = chroma;
      head.hue.rem     = hue_num[19:QUOT_BITS];
      head.hue.work    = hue_num[QUOT_BITS-1:0];
      head.sat.divisor = {den, 1'b0};
      head.sat.rem     = {4'd0, sat_num[16:QUOT_BITS]};
      head.sat.work    = sat_num[QUOT_BITS-1:0];
   end

endmodule

FILE: rtl/hsl_cell.sv
// ----------------------------------------------------------------------------
// HSL divider cell
// One restoring division step on the hue and saturation lanes per cell.
// ----------------------------------------------------------------------------
module hsl_cell
   import hsl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cell_type cell_prev,
   output cell_type cell_next
);

   cell_type    cell_ff;
   cell_type    cell_in;
   logic [9:0]  hue_diff;
   logic [10:0] sat_diff;
   logic        hue_ok;
   logic        sat_ok;

   always_comb begin
      cell_in  = cell_prev;
      hue_diff = {1'b0, cell_prev.hue.rem, cell_prev.hue.work[QUOT_BITS-1]}
               - {2'd0, cell_prev.hue.divisor};
      hue_ok   = !hue_diff[9];
      cell_in.hue.rem = hue_ok ? hue_diff[7:0]
                               : {cell_prev.hue.rem[6:0], cell_prev.hue.work[QUOT_BITS-1]};
      cell_in.hue.work = {cell_prev.hue.work[QUOT_BITS-2:0], hue_ok};
      sat_diff = {1'b0, cell_prev.sat.rem, cell_prev.sat.work[QUOT_BITS-1]}
               - {2'd0, cell_prev.sat.divisor};
      sat_ok   = !sat_diff[10];
      cell_in.sat.rem = sat_ok ? sat_diff[8:0]
                               : {cell_prev.sat.rem[7:0], cell_prev.sat.work[QUOT_BITS-1]};
      cell_in.sat.work = {cell_prev.sat.work[QUOT_BITS-2:0], sat_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (en) begin
         cell_ff.grey      <= cell_in.grey;
         cell_ff.dneg      <= cell_in.dneg;
         cell_ff.sector    <= cell_in.sector;
         cell_ff.lightness <= cell_in.lightness;
         cell_ff.hue       <= cell_in.hue;
         cell_ff.sat       <= cell_in.sat;
      end
   end

   assign cell_next = cell_ff;

endmodule

FILE: rtl/hsl_post.sv
// ----------------------------------------------------------------------------
// HSL output stage
// Turns quotients into hue and saturation and holds the result word.
// ----------------------------------------------------------------------------
module hsl_post
   import hsl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_last,
   output logic     out_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output hsl_type  rsp_word
);

   hsl_type     rsp_ff;
   hsl_type     rsp_in;
   logic        rsp_valid_ff;
   logic [14:0] base;
   logic [14:0] top;
   logic [14:0] quot;
   logic [14:0] adj;

   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cell_last.sector)
         SECTOR_RED:   base = BASE_RED;
         SECTOR_GREEN: base = BASE_GREEN;
         SECTOR_BLUE:  base = BASE_BLUE;
         default:      base = BASE_RED;
      endcase
      top  = (cell_last.sector == SECTOR_RED) ? HUE_FULL : base;
      quot = {3'd0, cell_last.hue.work};
      adj  = {14'd0, |cell_last.hue.rem};
      rsp_in.lightness = cell_last.lightness;
      if (cell_last.grey) begin
         rsp_in.hue        = 15'd0;
         rsp_in.saturation = 8'd0;
      end else begin
         rsp_in.hue        = cell_last.dneg ? (top - quot - adj) : (base + quot);
         rsp_in.saturation = cell_last.sat.work[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cell_last.valid;
      end
      if (out_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts 8-bit RGB pixels to hue, saturation and lightness at one per clock while unstalled.
// ----------------------------------------------------------------------------
// The request channel takes one RGB pixel per word on req_valid and req_ready.
// The response channel returns one HSL word per pixel, in order, on rsp_valid
// and rsp_ready. Hue is in 1/64 degree, saturation and lightness in 0 to 255.
// An accepted pixel is registered in the front stage, then passes a row of 12
// divider cells that each settle one quotient bit of hue and saturation, and
// one output register before it shows on rsp_valid. Unless the receiver stalls,
// the row takes a new word every cycle, for one pixel per clock sustained.
// Every stage holds its word when the one after it is full and stalled, and
// an empty stage still fills, so the block keeps accepting words while the
// receiver stalls until all 14 stages hold data; then req_ready drops.
// Synchronous reset empties all stages; no word is lost once accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsl_converter
   import hsl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  pixel_type req_word,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output hsl_type   rsp_word
);

   cell_type               stage [QUOT_BITS+1];
   logic [QUOT_BITS+1:0]   en;
   logic                   out_ready;

   assign en[QUOT_BITS+1] = out_ready;

   genvar k;
   generate
      for (k = 0; k <= QUOT_BITS; k++) begin : g_en
         assign en[k] = !stage[k].valid || en[k+1];
      end
   endgenerate

   assign req_ready = en[0];

   hsl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en[0]),
      .req_valid (req_valid),
      .req_word  (req_word),
      .head      (stage[0])
   );

   generate
      for (k = 0; k < QUOT_BITS; k++) begin : g_cell
         hsl_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en[k+1]),
            .cell_prev (stage[k]),
            .cell_next (stage[k+1])
         );
      end
   endgenerate

   hsl_post u_post (
      .clock     (clock),
      .reset     (reset),
      .cell_last (stage[QUOT_BITS]),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   `HSL_ASSERT(a_hue_range, clock, reset, rsp_valid |-> (rsp_word.hue < HUE_FULL))
   `HSL_ASSERT(a_take_front, clock, reset, (req_valid && req_ready) |=> stage[0].valid)
   `HSL_ASSERT(a_hold_last, clock, reset, (stage[QUOT_BITS].valid && !out_ready) |=> stage[QUOT_BITS].valid)
   `HSL_ASSERT_NEVER(a_grey_sat, clock, reset, rsp_valid && (rsp_word.saturation == 8'd0) && (rsp_word.hue != 15'd0))

endmodule
